// ===== design/cctsd_pkg.sv =====
package cctsd_pkg;

  // tooth counter value while position is unknown
  localparam logic [6:0] NoSyncTooth = 7'd99;
  localparam logic [6:0] ToothOne    = 7'd1;
  localparam logic [6:0] ToothThree  = 7'd3;
  localparam logic [6:0] ToothWrap   = 7'd5;

  // filter time after reset, in microseconds
  localparam logic [15:0] ResetFilter = 16'd1500;

  // tooth angles in degrees
  localparam logic [6:0] AngleShort = 7'd72;
  localparam logic [6:0] AngleLong  = 7'd108;

  // cam edge count that marks the sync point
  localparam logic [7:0] CamSyncCount = 8'd2;
  localparam logic [7:0] CamPostShort = 8'd3;

  // edge source codes
  localparam logic CmdPrimary   = 1'b0;
  localparam logic CmdSecondary = 1'b1;

  // coil end-of-charge request codes
  localparam logic [1:0] CoilNone = 2'd0;
  localparam logic [1:0] CoilOne  = 2'd1;
  localparam logic [1:0] CoilTwo  = 2'd2;

  // configuration register indexes, taken from paddr[2]
  localparam logic RegCrankLock     = 1'b0;
  localparam logic RegDefaultFilter = 1'b1;

endpackage

// ===== design/crank_cam_tooth_sync_decoder.sv =====
// channel   signals                                        direction
// input     in_valid_i / in_ready_o, cmd_i, timestamp_i,   in
//           cranking_i
// output    out_valid_o / out_ready_i, accepted_o .. revolutions_o  out
// config    psel, penable, pwrite, paddr, pwdata, prdata, pready     apb
//
// an edge transaction waits in the input register while the output is stalled, and
// the edge that moves it on updates the decoder state and loads the result register
// one transaction is accepted every cycle while the output side keeps taking results
// a stalled output holds its result and the input register, then in_ready_o drops
// rst_ni clears all decoder state and configuration at once, no clearing pass
module crank_cam_tooth_sync_decoder
  import cctsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] timestamp_i,
  input  logic        cranking_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [6:0]  tooth_number_o,
  output logic        sync_o,
  output logic [6:0]  tooth_angle_o,
  output logic [31:0] filter_time_o,
  output logic [1:0]  coil_end_o,
  output logic [31:0] last_tooth_time_o,
  output logic [31:0] prior_tooth_time_o,
  output logic [31:0] tooth_one_time_o,
  output logic [31:0] revolutions_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic        crank_lock_q;
  logic [15:0] default_filter_q;

  // input register
  logic        s1_valid_q;
  logic        s1_cmd_q;
  logic [31:0] s1_ts_q;
  logic        s1_cranking_q;

  // decoder state
  logic [6:0]  tooth_q, tooth_d;
  logic        sync_q, sync_d;
  logic [31:0] filter_q, filter_d;
  logic        angle_long_q, angle_long_d;
  logic [31:0] last_time_q, last_time_d;
  logic [31:0] prior_time_q, prior_time_d;
  logic [31:0] one_time_q, one_time_d;
  logic [31:0] rev_q, rev_d;
  logic [31:0] cam_last_q, cam_last_d;
  logic [31:0] cam_gap_q, cam_gap_d;
  logic [7:0]  cam_count_q, cam_count_d;

  // per-edge results
  logic        accepted_d;
  logic [1:0]  coil_d;

  // result register
  logic        out_valid_q;
  logic        accepted_q;
  logic [6:0]  tooth_out_q;
  logic        sync_out_q;
  logic        angle_out_q;
  logic [31:0] filter_out_q;
  logic [1:0]  coil_q;
  logic [31:0] last_out_q;
  logic [31:0] prior_out_q;
  logic [31:0] one_out_q;
  logic [31:0] rev_out_q;

  // handshake between stages
  logic out_free;
  logic s1_fire;
  logic in_fire;
  logic cfg_write;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // apb port, always ready
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      RegCrankLock:     prdata = {31'd0, crank_lock_q};
      RegDefaultFilter: prdata = {16'd0, default_filter_q};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crank_lock_q     <= 1'b0;
      default_filter_q <= ResetFilter;
    end else if (cfg_write) begin
      case (paddr[2])
        RegCrankLock:     crank_lock_q     <= pwdata[0];
        RegDefaultFilter: default_filter_q <= pwdata[15:0];
        default:          ;
      endcase
    end
  end

  // edge decode and state update
  always_comb begin
    logic [31:0] gap;
    logic [6:0]  next;
    logic        is_one;
    logic        sync_now;
    logic [33:0] gap_x3;

    gap    = s1_ts_q - last_time_q;
    next   = (tooth_q >= NoSyncTooth) ? NoSyncTooth : tooth_q + 7'd1;
    is_one = (next == ToothOne) || (next == ToothWrap);
    gap_x3 = {2'b00, gap} + {1'b0, gap, 1'b0};
    sync_now = sync_q || is_one;

    tooth_d      = tooth_q;
    sync_d       = sync_q;
    filter_d     = filter_q;
    angle_long_d = angle_long_q;
    last_time_d  = last_time_q;
    prior_time_d = prior_time_q;
    one_time_d   = one_time_q;
    rev_d        = rev_q;
    cam_last_d   = cam_last_q;
    cam_gap_d    = cam_gap_q;
    cam_count_d  = cam_count_q;
    accepted_d   = 1'b0;
    coil_d       = CoilNone;

    if (s1_cmd_q == CmdPrimary) begin
      if (gap >= filter_q) begin
        accepted_d = 1'b1;
        tooth_d    = is_one ? ToothOne : next;
        if (is_one) begin
          one_time_d = s1_ts_q;
          sync_d     = 1'b1;
          rev_d      = rev_q + 32'd1;
        end
        if (sync_now) begin
          if (s1_cranking_q && crank_lock_q) begin
            if (is_one) begin
              coil_d = CoilOne;
            end else if (next == ToothThree) begin
              coil_d = CoilTwo;
            end
          end
          // whole gap on teeth one and three, else 3/8 of it
          if (is_one || next == ToothThree) begin
            angle_long_d = 1'b0;
            filter_d     = gap;
          end else begin
            angle_long_d = 1'b1;
            filter_d     = {1'b0, gap_x3[33:3]};
          end
          prior_time_d = last_time_q;
          last_time_d  = s1_ts_q;
        end
      end
    end else begin
      cam_gap_d  = s1_ts_q - cam_last_q;
      cam_last_d = s1_ts_q;
      // search for the short cam gap before sync
      if (!sync_q) begin
        if (cam_count_q == CamSyncCount) begin
          tooth_d     = ToothOne;
          sync_d      = 1'b1;
          cam_count_d = CamPostShort;
        end else begin
          filter_d = {16'd0, default_filter_q};
          if (cam_gap_d < {1'b0, cam_gap_q[31:1]}) begin
            cam_count_d = CamPostShort;
          end else begin
            cam_count_d = cam_count_q + 8'd1;
          end
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q      <= cmd_i;
      s1_ts_q       <= timestamp_i;
      s1_cranking_q <= cranking_i;
    end
  end

  // decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tooth_q      <= NoSyncTooth;
      sync_q       <= 1'b0;
      filter_q     <= {16'd0, ResetFilter};
      angle_long_q <= 1'b1;
      last_time_q  <= 32'd0;
      prior_time_q <= 32'd0;
      one_time_q   <= 32'd0;
      rev_q        <= 32'd0;
      cam_last_q   <= 32'd0;
      cam_gap_q    <= 32'd0;
      cam_count_q  <= 8'd0;
    end else if (s1_fire) begin
      tooth_q      <= tooth_d;
      sync_q       <= sync_d;
      filter_q     <= filter_d;
      angle_long_q <= angle_long_d;
      last_time_q  <= last_time_d;
      prior_time_q <= prior_time_d;
      one_time_q   <= one_time_d;
      rev_q        <= rev_d;
      cam_last_q   <= cam_last_d;
      cam_gap_q    <= cam_gap_d;
      cam_count_q  <= cam_count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      accepted_q   <= accepted_d;
      tooth_out_q  <= tooth_d;
      sync_out_q   <= sync_d;
      angle_out_q  <= angle_long_d;
      filter_out_q <= filter_d;
      coil_q       <= coil_d;
      last_out_q   <= last_time_d;
      prior_out_q  <= prior_time_d;
      one_out_q    <= one_time_d;
      rev_out_q    <= rev_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign accepted_o         = accepted_q;
  assign tooth_number_o     = tooth_out_q;
  assign sync_o             = sync_out_q;
  assign tooth_angle_o      = angle_out_q ? AngleLong : AngleShort;
  assign filter_time_o      = filter_out_q;
  assign coil_end_o         = coil_q;
  assign last_tooth_time_o  = last_out_q;
  assign prior_tooth_time_o = prior_out_q;
  assign tooth_one_time_o   = one_out_q;
  assign revolutions_o      = rev_out_q;

endmodule

// ===== tb/sv/crank_cam_tooth_sync_decoder_tb.sv =====
module crank_cam_tooth_sync_decoder_tb;
  import cctsd_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  // largest filter time that ordinary tooth gaps get past within a few edges
  localparam logic [31:0] FilterCeiling = 32'd20000;
  localparam int SyncedRunLength = 215;

  // one decoded result as seen on the output port
  typedef struct packed {
    logic        accepted;
    logic [6:0]  tooth;
    logic        sync;
    logic [6:0]  angle;
    logic [31:0] filter;
    logic [1:0]  coil;
    logic [31:0] last;
    logic [31:0] prior;
    logic [31:0] one;
    logic [31:0] revs;
  } decode_t;

  // decoder state mirror, expected decodes and their comparison
  class tooth_sync_scoreboard;
    logic        lock_en     = 1'b0;
    logic [15:0] dflt_filter = ResetFilter;
    logic [6:0]  tooth       = NoSyncTooth;
    logic        synced      = 1'b0;
    logic [31:0] filter      = {16'd0, ResetFilter};
    logic [6:0]  angle       = AngleLong;
    logic [31:0] last        = '0;
    logic [31:0] prior       = '0;
    logic [31:0] one_time    = '0;
    logic [31:0] revs        = '0;
    logic [31:0] cam_last    = '0;
    logic [31:0] cam_gap     = '0;
    logic [7:0]  cam_count   = '0;
    decode_t     pending_decodes[$];
    int          errors      = 0;
    int          checked     = 0;
    int          crank_hits  = 0;
    int          crank_drops = 0;
    int          cam_edges   = 0;
    int          coil_reqs   = 0;

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == RegCrankLock) begin
        lock_en = value[0];
      end else begin
        dflt_filter = value[15:0];
      end
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_reg(logic idx, logic [31:0] got);
      if (idx == RegCrankLock) begin
        match_field("prdata crank_lock_enable", {31'd0, lock_en}, got);
      end else begin
        match_field("prdata default_filter_us", {16'd0, dflt_filter}, got);
      end
    endfunction

    // advance the mirrored decoder by one edge transaction and queue its result
    function void decode_edge(logic cmd, logic [31:0] ts, logic cranking);
      decode_t     d;
      logic [31:0] gap;
      logic [31:0] prev_gap;
      logic [6:0]  nxt;
      logic [63:0] wide;
      d = '0;
      if (cmd == CmdPrimary) begin
        gap = ts - last;
        if (gap >= filter) begin
          d.accepted = 1'b1;
          crank_hits++;
          // no position yet: the counter holds instead of wrapping
          nxt = (tooth >= NoSyncTooth) ? NoSyncTooth : tooth + 7'd1;
          if (nxt == ToothOne || nxt == ToothWrap) begin
            nxt = ToothOne;
            one_time = ts;
            synced = 1'b1;
            revs = revs + 32'd1;
          end
          tooth = nxt;
          if (synced) begin
            if (cranking && lock_en) begin
              if (nxt == ToothOne) d.coil = CoilOne;
              else if (nxt == ToothThree) d.coil = CoilTwo;
            end
            // short gap ends on teeth one and three
            if (nxt == ToothOne || nxt == ToothThree) begin
              angle = AngleShort;
              filter = gap;
            end else begin
              angle = AngleLong;
              wide = {32'd0, gap} * 64'd3;
              filter = wide[34:3];
            end
            prior = last;
            last = ts;
          end
        end else begin
          crank_drops++;
        end
      end else begin
        cam_edges++;
        prev_gap = cam_gap;
        cam_gap = ts - cam_last;
        cam_last = ts;
        // cam edges only search for the short gap while unsynced
        if (!synced) begin
          if (cam_count == CamSyncCount) begin
            tooth = ToothOne;
            synced = 1'b1;
          end else begin
            filter = {16'd0, dflt_filter};
            if (cam_gap < (prev_gap >> 1)) cam_count = CamSyncCount;
          end
          cam_count = cam_count + 8'd1;
        end
      end
      if (d.coil != CoilNone) coil_reqs++;
      d.tooth  = tooth;
      d.sync   = synced;
      d.angle  = angle;
      d.filter = filter;
      d.last   = last;
      d.prior  = prior;
      d.one    = one_time;
      d.revs   = revs;
      pending_decodes.push_back(d);
    endfunction

    function void check_decode(decode_t got);
      decode_t want;
      if (pending_decodes.size() == 0) begin
        $error("decode result with no edge transaction pending");
        errors++;
        return;
      end
      want = pending_decodes.pop_front();
      checked++;
      match_field("accepted", 32'(want.accepted), 32'(got.accepted));
      match_field("tooth_number", 32'(want.tooth), 32'(got.tooth));
      match_field("sync", 32'(want.sync), 32'(got.sync));
      match_field("tooth_angle", 32'(want.angle), 32'(got.angle));
      match_field("filter_time", want.filter, got.filter);
      match_field("coil_end", 32'(want.coil), 32'(got.coil));
      match_field("last_tooth_time", want.last, got.last);
      match_field("prior_tooth_time", want.prior, got.prior);
      match_field("tooth_one_time", want.one, got.one);
      match_field("revolutions", want.revs, got.revs);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        cmd_i       = CmdPrimary;
  logic [31:0] timestamp_i = '0;
  logic        cranking_i  = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        accepted_o;
  logic [6:0]  tooth_number_o;
  logic        sync_o;
  logic [6:0]  tooth_angle_o;
  logic [31:0] filter_time_o;
  logic [1:0]  coil_end_o;
  logic [31:0] last_tooth_time_o;
  logic [31:0] prior_tooth_time_o;
  logic [31:0] tooth_one_time_o;
  logic [31:0] revolutions_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  tooth_sync_scoreboard sb;
  int unsigned cycles = 0;
  logic        calm = 1'b0;

  // engine model used to shape well-formed tooth sequences
  logic [31:0] crank_t;
  int          gen_tooth;
  int          speed;
  logic        cranking;

  crank_cam_tooth_sync_decoder DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .timestamp_i        (timestamp_i),
    .cranking_i         (cranking_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .accepted_o         (accepted_o),
    .tooth_number_o     (tooth_number_o),
    .sync_o             (sync_o),
    .tooth_angle_o      (tooth_angle_o),
    .filter_time_o      (filter_time_o),
    .coil_end_o         (coil_end_o),
    .last_tooth_time_o  (last_tooth_time_o),
    .prior_tooth_time_o (prior_tooth_time_o),
    .tooth_one_time_o   (tooth_one_time_o),
    .revolutions_o      (revolutions_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("crank_cam_tooth_sync_decoder test failed");
      $finish;
    end
  end

  // monitor both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.decode_edge(cmd_i, timestamp_i, cranking_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_decode({accepted_o, tooth_number_o, sync_o, tooth_angle_o, filter_time_o,
                       coil_end_o, last_tooth_time_o, prior_tooth_time_o,
                       tooth_one_time_o, revolutions_o});
    end
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side backpressure
  initial begin : ready_gen
    int hold;
    int stall;
    wait (rst_ni);
    forever begin
      hold = $urandom_range(1, 30);
      out_ready_i <= 1'b1;
      repeat (hold) @(posedge clk_i);
      stall = idle_len();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // one edge transaction, then a random idle gap
  task automatic send_edge(input logic cmd, input logic [31:0] ts, input logic cr);
    int gap;
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    timestamp_i <= ts;
    cranking_i  <= cr;
    do @(posedge clk_i); while (!in_ready_o);
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off the sender until every decode is back
  task automatic drain_pending();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_decodes.size() > 0);
    repeat (4) @(posedge clk_i);
  endtask

  // apb write, then read back the same register
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [2:0] addr;
    addr = {idx, 2'b00};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.check_reg(idx, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // bring the filter down to ordinary gaps and pick up the tooth position
  task automatic realign_engine();
    drain_pending();
    while (sb.filter > FilterCeiling) begin
      send_edge(CmdPrimary, sb.last + sb.filter, cranking);
      drain_pending();
    end
    crank_t = sb.last;
    gen_tooth = int'(sb.tooth);
  endtask

  // stimulus
  initial begin : stimulus
    int          r;
    int          n;
    int          nxt;
    int unsigned gap;
    logic [31:0] cam_t;
    sb = new();
    cranking = 1'b1;
    speed = 100;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(RegCrankLock, 32'd1);
    write_reg(RegDefaultFilter, {16'd0, ResetFilter});
    // crank edges with no sync: filter boundary, held tooth, top timestamp
    send_edge(CmdPrimary, 32'd0, 1'b0);
    send_edge(CmdPrimary, 32'd1499, 1'b1);
    send_edge(CmdPrimary, 32'd1500, 1'b1);
    send_edge(CmdPrimary, 32'hFFFF_FFFF, 1'b0);
    // cam edges across the timestamp wrap, the second one a short gap
    send_edge(CmdSecondary, 32'hFFFF_F000, 1'b1);
    send_edge(CmdSecondary, 32'h0000_0100, 1'b0);
    drain_pending();
    // zero default filter lets a crank edge with no gap through
    write_reg(RegDefaultFilter, 32'd0);
    send_edge(CmdSecondary, 32'h0000_0200, 1'b0);
    send_edge(CmdPrimary, 32'd0, 1'b1);
    drain_pending();
    write_reg(RegDefaultFilter, 32'h0000_FFFF);
    send_edge(CmdSecondary, 32'h0000_0300, 1'b1);
    send_edge(CmdPrimary, 32'd65534, 1'b1);
    send_edge(CmdPrimary, 32'd65535, 1'b1);
    send_edge(CmdPrimary, 32'h8000_0000, 1'b0);

    // unsynced: cam count has to wrap round before sync, crank edges random
    cam_t = 32'h0000_0300;
    n = 0;
    while (!sb.synced) begin
      calm = (n >= 200 && n < 260);
      if (n == 150) begin
        drain_pending();
        write_reg(RegDefaultFilter, 32'($urandom_range(0, 65535)));
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        cam_t = cam_t + 32'($urandom_range(1000, 1999));
        send_edge(CmdSecondary, cam_t, r[0]);
      end else if (r < 50 && n < 60) begin
        // short cam gap restarts the count
        cam_t = cam_t + 32'($urandom_range(1, 400));
        send_edge(CmdSecondary, cam_t, r[1]);
      end else begin
        send_edge(CmdPrimary, $urandom(), 1'($urandom_range(0, 1)));
      end
      n++;
    end

    // synced: tooth sequences with noise, under several register settings
    for (int phase = 0; phase < 4; phase++) begin
      calm = 1'b0;
      drain_pending();
      case (phase)
        0: begin
          write_reg(RegCrankLock, 32'd1);
          write_reg(RegDefaultFilter, 32'h0000_FFFF);
        end
        1: begin
          write_reg(RegCrankLock, 32'd0);
          write_reg(RegDefaultFilter, 32'd0);
        end
        2: begin
          write_reg(RegCrankLock, 32'd1);
          write_reg(RegDefaultFilter, 32'($urandom_range(0, 65535)));
        end
        default: begin
          write_reg(RegCrankLock, 32'($urandom_range(0, 1)));
          write_reg(RegDefaultFilter, 32'($urandom_range(0, 65535)));
        end
      endcase
      realign_engine();
      if (phase == 0) begin
        // very long gap: filter from a gap whose triple overflows 32 bits
        send_edge(CmdPrimary, crank_t + 32'hF000_0000, cranking);
        realign_engine();
      end
      speed = $urandom_range(20, 400);
      for (n = 0; n < SyncedRunLength; n++) begin
        calm = (n >= 100 && n < 140);
        if (n % 60 == 59) realign_engine();
        if ($urandom_range(0, 19) == 0) cranking = ~cranking;
        speed = speed + int'($urandom_range(0, 10)) - 5;
        if (speed < 20) speed = 20;
        if (speed > 400) speed = 400;
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // next real tooth: short gap into teeth one and three
          nxt = (gen_tooth % 4) + 1;
          gap = (nxt == 1 || nxt == 3) ? 72 * speed : 108 * speed;
          gap = gap + $urandom_range(0, speed);
          crank_t = crank_t + gap;
          send_edge(CmdPrimary, crank_t, cranking);
          gen_tooth = nxt;
        end else if (r < 84) begin
          // spurious crank edge inside the filter window
          send_edge(CmdPrimary, crank_t + 32'($urandom_range(1, 30 * speed)), cranking);
        end else if (r < 99) begin
          send_edge(CmdSecondary, $urandom(), cranking);
        end else begin
          // wild crank edge, far jump or any timestamp
          if ($urandom_range(0, 1) == 0) crank_t = crank_t + $urandom();
          else crank_t = $urandom();
          send_edge(CmdPrimary, crank_t, cranking);
          realign_engine();
        end
      end
    end

    calm = 1'b0;
    drain_pending();
    $display("edges: %0d crank (%0d through the filter, %0d filtered), %0d cam; %0d checked",
             sb.crank_hits + sb.crank_drops, sb.crank_hits, sb.crank_drops, sb.cam_edges,
             sb.checked);
    $display("tooth-one events %0d, coil end requests %0d, sync reached %0d",
             sb.revs, sb.coil_reqs, sb.synced);
    if (sb.errors == 0) begin
      $display("crank_cam_tooth_sync_decoder test passed");
    end else begin
      $display("crank_cam_tooth_sync_decoder test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/cctsd_pkg.sv
design/crank_cam_tooth_sync_decoder.sv
tb/sv/crank_cam_tooth_sync_decoder_tb.sv
